/* rtl/core/assert_macros.svh */
// assertion macros shared by the console rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication within the same cycle
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent now, consequent in the following cycle
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tcw_pkg.sv */
// types, codes and glyph table of the text console
`default_nettype none
package tcw_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_byte;
    logic [3:0]  fg_color;
    logic        last_of_string;
    logic [11:0] read_index;
  } req_t;

  typedef struct packed {
    logic        cell_written;
    logic [11:0] cell_index;
    logic [15:0] cell_value;
    logic [11:0] cursor_pos;
    logic        scrolled;
    logic [15:0] read_data;
  } res_t;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CFG_BG    = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_ROWS  = 2'd2;
  localparam logic [1:0] CFG_MODE  = 2'd3;

  localparam logic [3:0] BG_RESET   = 4'd0;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [5:0] ROWS_RESET = 6'd24;
  localparam logic       MODE_RESET = 1'b1;
  localparam logic [8:0] COLS_DFLT  = 9'd80;
  localparam logic [6:0] ROWS_DFLT  = 7'd24;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] LEAD_C0  = 8'hC0;
  localparam logic [7:0] LEAD_C2  = 8'hC2;
  localparam logic [7:0] LEAD_C3  = 8'hC3;
  localparam logic [7:0] LEAD_C5  = 8'hC5;
  localparam logic [3:0] FG_CLEAR = 4'h7;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_C3   = 2'd1;
  localparam logic [1:0] PEND_C4   = 2'd2;
  localparam logic [1:0] PEND_C5   = 2'd3;

  // second byte of a two-byte sequence to code-page glyph
  function automatic logic [7:0] map_glyph(input logic [1:0] lead, input logic [7:0] b);
    logic [7:0] g;
    g = CH_QMARK;
    case (lead)
      PEND_C3: begin
        case (b)
          8'h96: g = 8'hD6;
          8'h9C: g = 8'hDC;
          8'hA7: g = 8'hE7;
          8'hB6: g = 8'hF6;
          8'hBC: g = 8'hFC;
          default: g = CH_QMARK;
        endcase
      end
      PEND_C4: begin
        case (b)
          8'h9E: g = 8'hD0;
          8'hB0: g = 8'hDD;
          8'hB1: g = 8'hEF;
          8'h9F: g = 8'hF0;
          default: g = CH_QMARK;
        endcase
      end
      PEND_C5: begin
        case (b)
          8'h9E: g = 8'hA6;
          8'h9F: g = 8'hB6;
          default: g = CH_QMARK;
        endcase
      end
      default: g = CH_QMARK;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tcw_ram.sv */
// generic single-clock ram, one write port and one registered read port
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/text_console_cell_writer.sv */
// text console: screen memory, cursor, scrolling and utf-8 folding
//
// Requests enter on in_req, taken at a clock edge with start high and busy
// low. Each request gives one result on out_res, marked by out_valid for a
// single cycle; the receiver always takes it.
// A put that writes a cell or moves the cursor answers in the cycle after it
// is taken. A put that runs off the last row scrolls: the new bottom row is
// blanked one cell per cycle, and the put answers once that row is blank.
// A read finds its row by shift-subtract in S_DIV, then reads the screen ram
// in S_READ and S_RDWAIT and answers; an index at or past width * height
// answers with zero read_data. A clear writes every visible cell, one per
// cycle. The screen ram has one write and one read port.
// Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once;
// a width or height write homes the cursor and the row ring.
// Reset homes the cursor and the ring, drops pending utf-8 state and loads
// the default geometry; screen contents are undefined until a clear.
`default_nettype none
module text_console_cell_writer #(
  parameter int MAX_COLS   = 128,
  parameter int ROWS_LIMIT = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire tcw_pkg::req_t in_req,
  output logic               out_valid,
  output tcw_pkg::res_t      out_res,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_wdata
);

`include "assert_macros.svh"

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(ROWS_LIMIT + 1);
  localparam int DEPTH = MAX_COLS * ROWS_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DEPTH + 1);
  localparam int KW    = $clog2(RW);
  localparam int SW    = 20;

  typedef enum logic [2:0] {
    S_IDLE, S_SCROLL, S_CLEAR, S_DIV, S_READ, S_RDWAIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [IW-1:0] cur_idx_r, cur_idx_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [1:0]    pend_r, pend_nxt;
  logic          skip_r, skip_nxt;
  logic [3:0]    bg_r, bg_nxt;
  logic [7:0]    cols_r, cols_nxt;
  logic [5:0]    rows_r, rows_nxt;
  logic          mode_r, mode_nxt;
  logic          out_valid_r, out_valid_nxt;
  tcw_pkg::res_t res_r, res_nxt;
  logic [RW-1:0] walk_row_r, walk_row_nxt;
  logic [CW-1:0] walk_col_r, walk_col_nxt;
  logic [3:0]    blank_fg_r, blank_fg_nxt;
  logic [RW-1:0] q_r, q_nxt;
  logic [11:0]   rem_r, rem_nxt;
  logic [KW-1:0] k_r, k_nxt;

  logic [8:0]    w_raw;
  logic [6:0]    h_raw;
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [IW-1:0] total;

  logic          dec_char, dec_nl, dec_cr, dec_bs, dec_skip;
  logic [7:0]    dec_ch;
  logic [1:0]    dec_pend;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data, rd_data;
  logic [SW-1:0] div_sh;
  logic          at_last_col, at_last_row;

  // logical row/col to physical ram address through the row ring
  function automatic logic [AW-1:0] phys(input logic [RW-1:0] row, input logic [CW-1:0] col,
                                         input logic [RW-1:0] top, input logic [RW-1:0] h);
    logic [RW:0] s;
    s = {1'b0, row} + {1'b0, top};
    if (s >= {1'b0, h}) begin
      s = s - {1'b0, h};
    end
    return AW'(AW'(s) * AW'(MAX_COLS)) + AW'(col);
  endfunction

  assign w_raw = (cols_r == 8'd0) ? tcw_pkg::COLS_DFLT : {1'b0, cols_r};
  assign h_raw = (rows_r == 6'd0) ? tcw_pkg::ROWS_DFLT : {1'b0, rows_r};
  assign eff_w = CW'((w_raw > 9'(MAX_COLS)) ? 9'(MAX_COLS) : w_raw);
  assign eff_h = RW'((h_raw > 7'(ROWS_LIMIT)) ? 7'(ROWS_LIMIT) : h_raw);
  assign total = IW'(IW'(eff_w) * IW'(eff_h));

  assign at_last_col = (cur_col_r == CW'(eff_w - 1'b1));
  assign at_last_row = (cur_row_r == RW'(eff_h - 1'b1));
  assign div_sh      = SW'(eff_w) << k_r;

  // byte decode for put requests
  always_comb begin
    dec_char = 1'b0;
    dec_ch   = in_req.char_byte;
    dec_nl   = 1'b0;
    dec_cr   = 1'b0;
    dec_bs   = 1'b0;
    dec_pend = pend_r;
    dec_skip = skip_r;
    if (skip_r) begin
      dec_skip = 1'b0;
    end else if (pend_r != tcw_pkg::PEND_NONE) begin
      dec_char = 1'b1;
      dec_ch   = (in_req.char_byte == tcw_pkg::CH_NUL) ? tcw_pkg::CH_QMARK
               : tcw_pkg::map_glyph(pend_r, in_req.char_byte);
      dec_pend = tcw_pkg::PEND_NONE;
    end else if (in_req.char_byte == tcw_pkg::CH_NUL) begin
      dec_char = 1'b0;
    end else if (in_req.char_byte == tcw_pkg::CH_NL) begin
      dec_nl = 1'b1;
    end else if (in_req.char_byte == tcw_pkg::CH_CR) begin
      dec_cr = 1'b1;
    end else if (in_req.char_byte == tcw_pkg::CH_BS) begin
      dec_bs = 1'b1;
    end else if (!in_req.char_byte[7]) begin
      dec_char = 1'b1;
    end else if (mode_r && in_req.char_byte >= tcw_pkg::LEAD_C3
                 && in_req.char_byte <= tcw_pkg::LEAD_C5) begin
      if (in_req.last_of_string) begin
        dec_char = 1'b1;
        dec_ch   = tcw_pkg::CH_QMARK;
      end else begin
        dec_pend = 2'(in_req.char_byte - tcw_pkg::LEAD_C2);
      end
    end else begin
      dec_char = 1'b1;
      dec_ch   = tcw_pkg::CH_QMARK;
      if (!mode_r && in_req.char_byte >= tcw_pkg::LEAD_C0 && !in_req.last_of_string) begin
        dec_skip = 1'b1;
      end
    end
    if (in_req.last_of_string) begin
      dec_pend = tcw_pkg::PEND_NONE;
      dec_skip = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    cur_idx_nxt   = cur_idx_r;
    top_nxt       = top_r;
    pend_nxt      = pend_r;
    skip_nxt      = skip_r;
    bg_nxt        = bg_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    walk_row_nxt  = walk_row_r;
    walk_col_nxt  = walk_col_r;
    blank_fg_nxt  = blank_fg_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    k_nxt         = k_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          case (in_req.req_type)
            tcw_pkg::REQ_PUT: begin
              pend_nxt      = dec_pend;
              skip_nxt      = dec_skip;
              out_valid_nxt = 1'b1;
              if (dec_char) begin
                wr_en   = 1'b1;
                wr_addr = phys(cur_row_r, cur_col_r, top_r, eff_h);
                wr_data = {bg_r, in_req.fg_color, dec_ch};
                res_nxt.cell_written = 1'b1;
                res_nxt.cell_index   = 12'(cur_idx_r);
                res_nxt.cell_value   = wr_data;
                cur_idx_nxt = cur_idx_r + 1'b1;
                if (at_last_col) begin
                  cur_col_nxt = '0;
                  cur_row_nxt = cur_row_r + 1'b1;
                end else begin
                  cur_col_nxt = cur_col_r + 1'b1;
                end
              end else if (dec_nl) begin
                cur_idx_nxt = IW'(cur_idx_r - IW'(cur_col_r) + IW'(eff_w));
                cur_col_nxt = '0;
                cur_row_nxt = cur_row_r + 1'b1;
              end else if (dec_cr) begin
                cur_idx_nxt = IW'(cur_idx_r - IW'(cur_col_r));
                cur_col_nxt = '0;
              end else if (dec_bs && cur_idx_r != '0) begin
                cur_idx_nxt = cur_idx_r - 1'b1;
                if (cur_col_r == '0) begin
                  cur_col_nxt = CW'(eff_w - 1'b1);
                  cur_row_nxt = cur_row_r - 1'b1;
                end else begin
                  cur_col_nxt = cur_col_r - 1'b1;
                end
                wr_en   = 1'b1;
                wr_addr = phys(cur_row_nxt, cur_col_nxt, top_r, eff_h);
                wr_data = {bg_r, in_req.fg_color, tcw_pkg::CH_SPACE};
                res_nxt.cell_written = 1'b1;
                res_nxt.cell_index   = 12'(cur_idx_nxt);
                res_nxt.cell_value   = wr_data;
              end
              // ran off the last row: blank the old top row, which becomes the bottom
              if (((dec_char && at_last_col) || dec_nl) && at_last_row) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCROLL;
                walk_row_nxt  = top_r;
                walk_col_nxt  = '0;
                blank_fg_nxt  = in_req.fg_color;
                top_nxt       = (top_r == RW'(eff_h - 1'b1)) ? '0 : top_r + 1'b1;
                cur_row_nxt   = RW'(eff_h - 1'b1);
                cur_col_nxt   = '0;
                cur_idx_nxt   = IW'(total - IW'(eff_w));
                res_nxt.scrolled = 1'b1;
              end
              res_nxt.cursor_pos = 12'(cur_idx_nxt);
            end
            tcw_pkg::REQ_READ: begin
              res_nxt.cursor_pos = 12'(cur_idx_r);
              if (16'(in_req.read_index) >= 16'(total)) begin
                out_valid_nxt = 1'b1;
              end else begin
                rem_nxt   = in_req.read_index;
                q_nxt     = '0;
                k_nxt     = KW'(RW - 1);
                state_nxt = S_DIV;
              end
            end
            tcw_pkg::REQ_CLEAR: begin
              top_nxt      = '0;
              cur_row_nxt  = '0;
              cur_col_nxt  = '0;
              cur_idx_nxt  = '0;
              pend_nxt     = tcw_pkg::PEND_NONE;
              skip_nxt     = 1'b0;
              walk_row_nxt = '0;
              walk_col_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            default: begin
              res_nxt.cursor_pos = 12'(cur_idx_r);
              out_valid_nxt      = 1'b1;
            end
          endcase
        end
      end
      S_SCROLL: begin
        wr_en   = 1'b1;
        wr_addr = AW'(AW'(walk_row_r) * AW'(MAX_COLS)) + AW'(walk_col_r);
        wr_data = {bg_r, blank_fg_r, tcw_pkg::CH_SPACE};
        if (walk_col_r == CW'(eff_w - 1'b1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          walk_col_nxt = walk_col_r + 1'b1;
        end
      end
      S_CLEAR: begin
        // ring offset is zero here, so logical rows are physical rows
        wr_en   = 1'b1;
        wr_addr = AW'(AW'(walk_row_r) * AW'(MAX_COLS)) + AW'(walk_col_r);
        wr_data = {bg_r, tcw_pkg::FG_CLEAR, tcw_pkg::CH_SPACE};
        if (walk_col_r == CW'(eff_w - 1'b1)) begin
          walk_col_nxt = '0;
          if (walk_row_r == RW'(eff_h - 1'b1)) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            walk_row_nxt = walk_row_r + 1'b1;
          end
        end else begin
          walk_col_nxt = walk_col_r + 1'b1;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle: row = index / width, col = remainder
        if (SW'(rem_r) >= div_sh) begin
          rem_nxt = rem_r - 12'(div_sh);
          q_nxt   = {q_r[RW-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[RW-2:0], 1'b0};
        end
        if (k_r == '0) begin
          state_nxt = S_READ;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        rd_addr   = phys(q_r, CW'(rem_r), top_r, eff_h);
        state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        res_nxt.read_data = rd_data;
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_BG: bg_nxt = cfg_wdata[3:0];
        tcw_pkg::CFG_COLS: begin
          cols_nxt    = cfg_wdata;
          cur_row_nxt = '0;
          cur_col_nxt = '0;
          cur_idx_nxt = '0;
          top_nxt     = '0;
        end
        tcw_pkg::CFG_ROWS: begin
          rows_nxt    = cfg_wdata[5:0];
          cur_row_nxt = '0;
          cur_col_nxt = '0;
          cur_idx_nxt = '0;
          top_nxt     = '0;
        end
        tcw_pkg::CFG_MODE: mode_nxt = cfg_wdata[0];
        default: mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cur_idx_r   <= '0;
      top_r       <= '0;
      pend_r      <= tcw_pkg::PEND_NONE;
      skip_r      <= 1'b0;
      bg_r        <= tcw_pkg::BG_RESET;
      cols_r      <= tcw_pkg::COLS_RESET;
      rows_r      <= tcw_pkg::ROWS_RESET;
      mode_r      <= tcw_pkg::MODE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_idx_r   <= cur_idx_nxt;
      top_r       <= top_nxt;
      pend_r      <= pend_nxt;
      skip_r      <= skip_nxt;
      bg_r        <= bg_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    walk_row_r <= walk_row_nxt;
    walk_col_r <= walk_col_nxt;
    blank_fg_r <= blank_fg_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    k_r        <= k_nxt;
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `TCW_ASSERT(a_result_when_idle, out_valid |-> !busy, "result shown while busy")
  `TCW_ASSERT_NEXT(a_request_progress, start && !busy, busy || out_valid, "request lost")
  `TCW_ASSERT(a_cursor_on_screen, (cur_row_r < eff_h) && (cur_col_r < eff_w), "cursor off screen")
  `TCW_ASSERT(a_scroll_cursor, (out_valid && out_res.scrolled) |-> (out_res.cursor_pos == 12'(total - IW'(eff_w))), "scroll cursor not on last row")

endmodule
`default_nettype wire
